// ===== src/countdown_timer_pause_resume_core_defines.svh =====
// ----------------------------------------------------------------------------
// Countdown timer assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_PAUSE_RESUME_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_PAUSE_RESUME_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define CTPR_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define CTPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTPR_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define CTPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/ctpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Countdown timer package
// Item types, codes and constants shared by the countdown timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpr_pkg;

    localparam int MAX_MINUTES = 99;

    localparam int TIME_W    = 23;
    localparam int MINUTES_W = 7;
    localparam int WARN_W    = 16;

    // bit-serial divider geometry
    localparam int DIV_W      = 30;
    localparam int DIVISOR_W  = 23;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [DIVISOR_W-1:0] MS_PER_SECOND = DIVISOR_W'(1000);
    localparam logic [WARN_W-1:0] WARN_RESET = 16'd10000;
    localparam logic [MINUTES_W-1:0] PRESET_RESET = 7'd5;

    // 2^19 / 60 rounded up: exact floor(s / 60) for every whole-second count
    // up to 99 minutes
    localparam logic [13:0] RECIP_60 = 14'd8739;
    localparam int RECIP_SHIFT = 19;

    // input modes
    localparam logic [1:0] MODE_ADJUST = 2'd0;
    localparam logic [1:0] MODE_TOGGLE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // reported timer states
    localparam logic [1:0] TS_IDLE     = 2'd0;
    localparam logic [1:0] TS_RUNNING  = 2'd1;
    localparam logic [1:0] TS_PAUSED   = 2'd2;
    localparam logic [1:0] TS_FINISHED = 2'd3;

    // register map
    localparam logic REG_WARN_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [7:0] delta_minutes;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0]  shown_minutes;
        logic [5:0]  shown_seconds;
        logic [6:0]  progress_percent;
        logic [1:0]  timer_state;
        logic        warning;
        logic        alarm;
        logic [22:0] time_left_ms;
    } res_item_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_DIVIDE,
        CTL_SCALE,
        CTL_SPLIT
    } ctl_state_t;

endpackage

`default_nettype wire

// ===== src/ctpr_serial_div.sv =====
// ----------------------------------------------------------------------------
// Countdown timer bit-serial divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpr_serial_div
    import ctpr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // trial remainder: shift in next dividend bit
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // last step retires at this edge
    assign done     = (cnt_reg == DIV_CNT_W'(1));
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/ctpr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Countdown timer configuration registers
// APB-style register port holding the warning threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpr_cfg_regs
    import ctpr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic [WARN_W-1:0]      warn_threshold
);

    logic [WARN_W-1:0] warn_reg, warn_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        warn_next = warn_reg;
        if (wr_en && (paddr[2] == REG_WARN_THRESHOLD))
        begin
            warn_next = pwdata[WARN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg <= WARN_RESET;
        end
        else
        begin
            warn_reg <= warn_next;
        end
    end

    assign prdata = (paddr[2] == REG_WARN_THRESHOLD) ? {{(32-WARN_W){1'b0}}, warn_reg} : '0;
    assign warn_threshold = warn_reg;

endmodule

`default_nettype wire

// ===== src/countdown_timer_pause_resume_core.sv =====
// ----------------------------------------------------------------------------
// Countdown timer with pause and resume
// Minute countdown driven by adjust, toggle and millisecond tick items.
// ----------------------------------------------------------------------------
// Each cmd item (adjust, toggle or tick) updates the timer state in the cycle
// it is accepted and yields exactly one res item through the divide, scale
// and split states in that order; split waits for a free result slot. Two
// 30-bit restoring dividers of the same kind run alongside, one forming the
// percentage and one whole seconds. The next cmd item can be taken the cycle
// after the result is loaded, so an item is taken only once the last is
// through. cmd_ready is high only while no item is in flight, but the
// result register decouples the two sides, so the next cmd item is taken
// while a result still waits on res_ready. Warning threshold sits at
// register 0 (byte address 0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_timer_pause_resume_core_defines.svh"

module countdown_timer_pause_resume_core
    import ctpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire cmd_item_t   cmd,
    // result channel
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_item_t        res,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [WARN_W-1:0] warn_threshold;

    ctpr_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .warn_threshold (warn_threshold)
    );

    // ------------------------------------------------------------------
    // timer state
    // ------------------------------------------------------------------
    logic [MINUTES_W-1:0] preset_reg, preset_next;
    logic [TIME_W-1:0]    time_left_reg, time_left_next;
    logic [TIME_W-1:0]    span_reg, span_next;
    logic                 running_reg, running_next;
    logic                 finished_reg, finished_next;
    logic                 alarm_reg, alarm_next;

    ctl_state_t state_reg, state_next;

    logic cmd_accept;
    logic div_start;
    logic res_load;

    assign cmd_accept = cmd_valid & cmd_ready;

    // adjust: full-precision sum, then clamp to 1..MAX_MINUTES
    logic signed [8:0]    adj_sum;
    logic [TIME_W-1:0]    start_span;
    logic [TIME_W-1:0]    tick_left;

    assign adj_sum    = $signed({2'b00, preset_reg})
                      + $signed({cmd.delta_minutes[7], cmd.delta_minutes});
    assign start_span = {{(TIME_W-MINUTES_W){1'b0}}, preset_reg}
                      * {{(TIME_W-16){1'b0}}, MS_PER_MINUTE};
    assign tick_left  = (time_left_reg != '0) ? time_left_reg - 1'b1 : time_left_reg;

    always_comb
    begin
        preset_next    = preset_reg;
        time_left_next = time_left_reg;
        span_next      = span_reg;
        running_next   = running_reg;
        finished_next  = finished_reg;
        alarm_next     = alarm_reg;
        if (cmd_accept)
        begin
            alarm_next = 1'b0;
            case (cmd.mode)
                MODE_ADJUST:
                begin
                    if (!running_reg)
                    begin
                        finished_next  = 1'b0;
                        time_left_next = '0;
                        if (adj_sum < 9'sd1)
                        begin
                            preset_next = 7'd1;
                        end
                        else if (adj_sum > $signed(9'(MAX_MINUTES)))
                        begin
                            preset_next = MINUTES_W'(MAX_MINUTES);
                        end
                        else
                        begin
                            preset_next = adj_sum[MINUTES_W-1:0];
                        end
                    end
                end
                MODE_TOGGLE:
                begin
                    if (finished_reg)
                    begin
                        // clear a finished timer back to idle
                        finished_next  = 1'b0;
                        time_left_next = '0;
                    end
                    else if (running_reg)
                    begin
                        // pause keeps time left untouched
                        running_next = 1'b0;
                    end
                    else if (time_left_reg == '0)
                    begin
                        // fresh start from the preset
                        time_left_next = start_span;
                        span_next      = start_span;
                        running_next   = (start_span != '0);
                    end
                    else
                    begin
                        running_next = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (running_reg)
                    begin
                        time_left_next = tick_left;
                        if (tick_left == '0)
                        begin
                            running_next  = 1'b0;
                            finished_next = 1'b1;
                            alarm_next    = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // unused mode: state kept but for the alarm, result reports it
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg    <= PRESET_RESET;
            time_left_reg <= '0;
            span_reg      <= '0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            alarm_reg     <= 1'b0;
        end
        else
        begin
            preset_reg    <= preset_next;
            time_left_reg <= time_left_next;
            span_reg      <= span_next;
            running_reg   <= running_next;
            finished_reg  <= finished_next;
            alarm_reg     <= alarm_next;
        end
    end

    // ------------------------------------------------------------------
    // dividers: whole seconds = time_left / 1000, percent = time_left*100 / span
    // both start on the accept edge from the freshly updated time left
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] sec_dividend;
    logic [DIV_W-1:0] pct_dividend;
    logic [DIV_W-1:0] sec_quo;
    logic [DIV_W-1:0] pct_quo;
    logic             sec_done;
    logic             pct_done;

    assign sec_dividend = {{(DIV_W-TIME_W){1'b0}}, time_left_next};
    // x100 as shifts and adds; cannot overflow 30 bits
    assign pct_dividend = (sec_dividend << 6) + (sec_dividend << 5) + (sec_dividend << 2);

    ctpr_serial_div u_sec_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sec_dividend),
        .divisor  (MS_PER_SECOND),
        .done     (sec_done),
        .quotient (sec_quo)
    );

    ctpr_serial_div u_pct_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pct_dividend),
        .divisor  (span_next),
        .done     (pct_done),
        .quotient (pct_quo)
    );

    // ------------------------------------------------------------------
    // minutes by reciprocal of 60, then seconds as the remainder
    // ------------------------------------------------------------------
    logic [27:0] scale_reg, scale_next;
    logic [7:0]  mins_full;
    logic [13:0] whole_secs;
    logic [13:0] mins_x60;
    logic [13:0] secs_full;

    assign whole_secs = sec_quo[13:0];

    always_comb
    begin
        scale_next = scale_reg;
        if (state_reg == CTL_SCALE)
        begin
            scale_next = 28'(whole_secs) * 28'(RECIP_60);
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
    end

    assign mins_full = scale_reg[RECIP_SHIFT+7:RECIP_SHIFT];
    assign mins_x60  = {6'b0, mins_full} * 14'd60;
    assign secs_full = whole_secs - mins_x60;

    // ------------------------------------------------------------------
    // control sequencer
    // ------------------------------------------------------------------
    logic res_valid_reg, res_valid_next;
    logic res_slot_free;

    assign res_slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = CTL_DIVIDE;
                end
            end
            CTL_DIVIDE:
            begin
                if (sec_done)
                begin
                    state_next = CTL_SCALE;
                end
            end
            CTL_SCALE:
            begin
                state_next = CTL_SPLIT;
            end
            CTL_SPLIT:
            begin
                if (res_slot_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            CTL_SPLIT:
            begin
                res_load = res_slot_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
                res_load  = 1'b0;
            end
        endcase
    end

    assign div_start = cmd_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // result assembly and output register
    // ------------------------------------------------------------------
    res_item_t res_reg, res_next;
    res_item_t res_item;

    always_comb
    begin
        res_item.warning = running_reg
                         && (time_left_reg < {{(TIME_W-WARN_W){1'b0}}, warn_threshold});
        res_item.alarm   = alarm_reg;
        if (finished_reg)
        begin
            res_item.shown_minutes    = '0;
            res_item.shown_seconds    = '0;
            res_item.progress_percent = '0;
            res_item.timer_state      = TS_FINISHED;
            res_item.time_left_ms     = '0;
        end
        else if (!running_reg && (time_left_reg == '0))
        begin
            res_item.shown_minutes    = preset_reg;
            res_item.shown_seconds    = '0;
            res_item.progress_percent = 7'd100;
            res_item.timer_state      = TS_IDLE;
            res_item.time_left_ms     = time_left_reg;
        end
        else
        begin
            res_item.shown_minutes = mins_full[6:0];
            res_item.shown_seconds = secs_full[5:0];
            // zero span reads as no progress; anything above 100 saturates
            if (span_reg == '0)
            begin
                res_item.progress_percent = '0;
            end
            else if (pct_quo > DIV_W'(100))
            begin
                res_item.progress_percent = 7'd100;
            end
            else
            begin
                res_item.progress_percent = pct_quo[6:0];
            end
            res_item.timer_state  = running_reg ? TS_RUNNING : TS_PAUSED;
            res_item.time_left_ms = time_left_reg;
        end
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_next       = res_item;
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the two dividers run in lock step
    `CTPR_ASSERT_ALWAYS(a_div_lockstep, clk, rst_n, sec_done == pct_done, "dividers out of step")
    // time left never exceeds the span it was started from
    `CTPR_ASSERT_ALWAYS(a_left_le_span, clk, rst_n, time_left_reg <= span_reg, "left above span")
    // finished and running are exclusive
    `CTPR_ASSERT_ALWAYS(a_fin_not_run, clk, rst_n, !(finished_reg && running_reg), "finished while running")
    // an accepted item drops cmd_ready once it is taken
    `CTPR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, cmd_accept, !cmd_ready, "second item taken in flight")

endmodule

`default_nettype wire

// ===== tb/countdown_timer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer result check
// Watches the cmd, res and register channels of the countdown timer, keeps
// its own copy of the timer and compares every res item with the prediction.
// ----------------------------------------------------------------------------
module countdown_timer_check
    import ctpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  cmd_item_t   cmd,
    input  logic        res_valid,
    input  logic        res_ready,
    input  res_item_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int unsigned fail_count,
    output int unsigned outstanding,
    output int unsigned checked_count,
    output int unsigned alarm_count,
    output int unsigned warning_count
);

    localparam logic [2:0] WARN_ADDR = 3'(4 * int'(REG_WARN_THRESHOLD));
    localparam int unsigned PRINT_CAP = 50;

    // predicted timer state
    logic [MINUTES_W-1:0] timer_preset;
    logic [TIME_W-1:0]    timer_left;
    logic [TIME_W-1:0]    timer_span;
    logic                 timer_running;
    logic                 timer_expired;
    logic [WARN_W-1:0]    warn_limit;

    res_item_t   due_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned alarms_seen;
    int unsigned warnings_seen;

    task automatic flag_error(input string what, input int unsigned got,
                              input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("ERROR: t=%0t result %0d %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // apply one cmd item to the timer copy and form its res item
    task automatic advance_timer(input cmd_item_t c, output res_item_t r);
        int          sum;
        logic        fired;
        logic [63:0] scaled;
        fired = 1'b0;
        case (c.mode)
            MODE_ADJUST:
            begin
                if (!timer_running)
                begin
                    timer_expired = 1'b0;
                    sum = int'(timer_preset) + int'($signed(c.delta_minutes));
                    if (sum < 1)
                        sum = 1;
                    if (sum > MAX_MINUTES)
                        sum = MAX_MINUTES;
                    timer_preset = MINUTES_W'(sum);
                    timer_left = '0;
                end
            end
            MODE_TOGGLE:
            begin
                if (timer_expired)
                begin
                    timer_expired = 1'b0;
                    timer_left = '0;
                end
                else if (timer_running)
                    timer_running = 1'b0;
                else
                begin
                    if (timer_left == '0)
                    begin
                        timer_left = TIME_W'(32'(timer_preset) * 32'(MS_PER_MINUTE));
                        timer_span = timer_left;
                    end
                    timer_running = (timer_left != '0);
                end
            end
            MODE_TICK:
            begin
                if (timer_running)
                begin
                    if (timer_left != '0)
                        timer_left = timer_left - 1'b1;
                    if (timer_left == '0)
                    begin
                        timer_running = 1'b0;
                        timer_expired = 1'b1;
                        fired = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        r = '0;
        if (timer_expired)
            r.timer_state = TS_FINISHED;
        else if (!timer_running && timer_left == '0)
        begin
            r.timer_state = TS_IDLE;
            r.shown_minutes = timer_preset;
            r.progress_percent = 7'd100;
        end
        else
        begin
            r.timer_state = timer_running ? TS_RUNNING : TS_PAUSED;
            r.shown_minutes = 7'(32'(timer_left) / 32'(MS_PER_MINUTE));
            r.shown_seconds = 6'((32'(timer_left) % 32'(MS_PER_MINUTE)) /
                                 32'(MS_PER_SECOND));
            if (timer_span == '0)
                r.progress_percent = 7'd0;
            else
            begin
                scaled = (64'(timer_left) * 64'd100) / 64'(timer_span);
                r.progress_percent = (scaled > 64'd100) ? 7'd100 : 7'(scaled);
            end
            r.time_left_ms = timer_left;
        end
        r.warning = timer_running && (32'(timer_left) < 32'(warn_limit));
        r.alarm = fired;
    endtask

    task automatic compare_result(input res_item_t got, input res_item_t want);
        if (got.shown_minutes !== want.shown_minutes)
            flag_error("shown_minutes", got.shown_minutes, want.shown_minutes);
        if (got.shown_seconds !== want.shown_seconds)
            flag_error("shown_seconds", got.shown_seconds, want.shown_seconds);
        if (got.progress_percent !== want.progress_percent)
            flag_error("progress_percent", got.progress_percent, want.progress_percent);
        if (got.timer_state !== want.timer_state)
            flag_error("timer_state", got.timer_state, want.timer_state);
        if (got.warning !== want.warning)
            flag_error("warning", got.warning, want.warning);
        if (got.alarm !== want.alarm)
            flag_error("alarm", got.alarm, want.alarm);
        if (got.time_left_ms !== want.time_left_ms)
            flag_error("time_left_ms", got.time_left_ms, want.time_left_ms);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        res_item_t fresh;
        if (!rst_n)
        begin
            timer_preset = PRESET_RESET;
            timer_left = '0;
            timer_span = '0;
            timer_running = 1'b0;
            timer_expired = 1'b0;
            warn_limit = WARN_RESET;
            due_results.delete();
            mismatches = 0;
            results_seen = 0;
            alarms_seen = 0;
            warnings_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == WARN_ADDR)
                warn_limit = pwdata[WARN_W-1:0];

            // result side first: an item accepted now cannot answer in this cycle
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                    flag_error("unexpected item, state", res.timer_state, 0);
                else
                begin
                    want = due_results.pop_front();
                    compare_result(res, want);
                    if (want.alarm)
                        alarms_seen++;
                    if (want.warning)
                        warnings_seen++;
                end
                results_seen++;
            end

            if (cmd_valid && cmd_ready)
            begin
                advance_timer(cmd, fresh);
                due_results.push_back(fresh);
            end
        end
        fail_count    <= mismatches;
        outstanding   <= due_results.size();
        checked_count <= results_seen;
        alarm_count   <= alarms_seen;
        warning_count <= warnings_seen;
    end

endmodule

// ===== tb/countdown_timer_pause_resume_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer testbench
// Drives adjust, toggle and tick items into the countdown timer with bursty
// sending and a stalling receiver; the check module beside the block predicts
// every res item and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module countdown_timer_pause_resume_core_tb
    import ctpr_pkg::*;
();

    // mode 3 has no meaning to the block; it must leave the timer untouched
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] WARN_ADDR  = 3'(4 * int'(REG_WARN_THRESHOLD));

    localparam int LATENCY      = 32;     // accept to result
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int RANDOM_ITEMS = 250;    // per random segment, three segments

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // sink control, each written by the stimulus process only
    logic        sink_steady = 1'b0;
    int unsigned holds_asked = 0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked_count;
    int unsigned alarm_count;
    int unsigned warning_count;

    countdown_timer_pause_resume_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    countdown_timer_check u_timer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .alarm_count   (alarm_count),
        .warning_count (warning_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Present one cmd item and hold it until the block takes it. When called
    // straight after an accept, valid simply stays high with the new payload.
    task automatic offer(input logic [1:0] m, input int d);
        cmd_item_t c;
        c.mode = m;
        c.delta_minutes = d[7:0];
        cmd <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic idle_for(input int unsigned n);
        cmd_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every predicted item to come back. Each cmd item yields exactly
    // one res item, so once the queue is empty the block has nothing in flight.
    task automatic drain();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // setup cycle then access cycle; the register takes pwdata on the access edge
    task automatic write_threshold(input logic [WARN_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WARN_ADDR;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random mix weighted towards ticks so that runs and pauses last a while.
    // Half of the deltas are small nudges, the rest span the full byte, which
    // drives the clamp at both ends. Deltas go out on every mode so that all
    // payload bits toggle even where the block ignores them.
    task automatic random_segment(input int hold_at);
        int unsigned burst;
        int unsigned roll;
        logic [1:0]  m;
        int          d;
        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                // mostly short gaps that land inside the block's busy window,
                // now and then one long enough to find it idle
                if ($urandom_range(0, 3) == 0)
                    idle_for($urandom_range(25, 45));
                else
                    idle_for($urandom_range(1, 12));
            end
            burst--;
            if (n == hold_at)
                holds_asked++;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                m = MODE_TICK;
            else if (roll < 75)
                m = MODE_TOGGLE;
            else if (roll < 95)
                m = MODE_ADJUST;
            else
                m = MODE_SPARE;
            if ($urandom_range(0, 1) != 0)
                d = int'($urandom_range(0, 20)) - 10;
            else
                d = int'($urandom_range(0, 255));
            offer(m, d);
        end
    endtask

    // Receiver: alternating runs of ready and stall of random length, steady
    // ready when asked, and a long hold-off on request so the result register
    // fills and the block has to refuse further cmd items.
    initial
    begin : result_sink
        int unsigned stretch;
        int unsigned hold_left;
        int unsigned holds_done;
        logic        level;
        stretch = 0;
        hold_left = 0;
        holds_done = 0;
        level = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (sink_steady)
                res_ready <= 1'b1;
            else
            begin
                if (stretch == 0)
                begin
                    level = !level;
                    stretch = level ? $urandom_range(1, 40) : $urandom_range(1, 15);
                end
                stretch--;
                res_ready <= level;
            end
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edges with the threshold at its reset value.
        offer(MODE_TICK, 0);        // tick while idle does nothing
        offer(MODE_SPARE, 0);       // unused mode while idle
        offer(MODE_TOGGLE, 0);      // fresh start from the 5 minute preset
        offer(MODE_ADJUST, 10);     // adjust while running is ignored
        offer(MODE_TICK, 0);
        offer(MODE_TICK, 0);
        offer(MODE_SPARE, 0);       // unused mode while running
        offer(MODE_TOGGLE, 0);      // pause keeps time left as it is
        offer(MODE_TICK, 0);        // tick while paused is ignored
        offer(MODE_TOGGLE, 0);      // resume
        offer(MODE_TICK, 0);
        offer(MODE_TOGGLE, 0);      // pause again
        offer(MODE_ADJUST, 3);      // adjust while paused drops the paused time
        offer(MODE_ADJUST, -128);   // most negative delta, clamps to one minute
        offer(MODE_ADJUST, 127);    // most positive delta, clamps to the maximum
        offer(MODE_ADJUST, 99);     // sum well above the maximum
        offer(MODE_ADJUST, -99);    // sum of zero, clamps up
        offer(MODE_ADJUST, 99);     // sum of one over the maximum
        offer(MODE_ADJUST, 0);
        offer(MODE_TOGGLE, 0);      // start at the longest preset
        offer(MODE_TICK, 0);
        offer(MODE_TOGGLE, 0);
        offer(MODE_TOGGLE, 0);
        offer(MODE_TICK, 0);
        drain();

        // Warning edge: a one-minute run with the threshold two below its
        // start, so the warning rises on the third tick and drops on pause.
        // Sender and receiver run flat out.
        write_threshold(16'd59998);
        sink_steady = 1'b1;
        offer(MODE_ADJUST, -128);   // still running from above: ignored
        offer(MODE_TOGGLE, 0);      // pause
        offer(MODE_ADJUST, -128);   // back to idle with a one-minute preset
        offer(MODE_TOGGLE, 0);
        repeat (3) offer(MODE_TICK, 0);
        offer(MODE_TOGGLE, 0);      // pause mid-run
        offer(MODE_TICK, 0);
        offer(MODE_SPARE, 0);
        offer(MODE_TOGGLE, 0);      // resume
        offer(MODE_ADJUST, 5);      // ignored while running
        drain();
        sink_steady = 1'b0;

        // Random segments at the threshold extremes and one random setting.
        // The middle one carries the long receiver hold-off.
        write_threshold(16'd0);
        random_segment(-1);
        drain();
        write_threshold(16'hFFFF);
        random_segment(RANDOM_ITEMS / 2);
        drain();
        write_threshold(WARN_W'($urandom_range(0, 65535)));
        random_segment(-1);

        drain();
        // room for any stray res item to show up and be flagged
        repeat (2 * LATENCY) @(posedge clk);

        $display("Covered: %0d items checked - directed edges, clamps, pause and resume,",
                 checked_count);
        $display("a warning edge, %0d random items at three thresholds; alarms %0d, warnings %0d",
                 3 * RANDOM_ITEMS, alarm_count, warning_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A correct run needs well under a millisecond even with every stall at
    // its longest; this allows several times that.
    initial
    begin : watchdog
        #5_000_000;
        $display("ERROR: run timed out with %0d items outstanding", outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
